FILE: rtl/core/rpn_pkg.sv
// Package: shared constants, codes and types for the RPN stack calculator.
package rpn_pkg;
    localparam int StackDepth = 128;
    localparam int PtrW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);

    typedef enum logic [2:0] {
        MODE_PUSH  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_MUL   = 3'd3,
        MODE_DIV   = 3'd4,
        MODE_MOD   = 3'd5,
        MODE_PRINT = 3'd6,
        MODE_NONE  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZDIV  = 2'd3
    } status_t;

    localparam logic [63:0] QMax = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QMin = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [95:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;
endpackage

FILE: rtl/core/rpn_stack_calculator.sv
// Top level: RPN calculator sequencer over the operand stack memory.
// Push goes straight to write-back and the unused mode to output; print, add, sub,
// mul, mod and div pop operands first, mul runs its partial product states, and mod
// and div wait on the divider (64 or 96 divider steps) unless the divisor is zero.
// One word in flight at a time, until its result is taken; div sets the worst case.
// Reset (rst_n low, asynchronous) empties the stack and clears the sequencer;
// stack contents are not cleared and are never read before written.
module rpn_stack_calculator
    import rpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [2:0] mode, [66:3] number, [71:67] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [65:64] status, [71:66] zero
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD2   = 11'b00000000010,
        S_RD1   = 11'b00000000100,
        S_GOT1  = 11'b00000001000,
        S_MUL1  = 11'b00000010000,
        S_MUL2  = 11'b00000100000,
        S_MUL3  = 11'b00001000000,
        S_DIVW  = 11'b00010000000,
        S_WB    = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_GOT2  = 11'b10000000000
    } state_t;

    state_t          state_reg;
    logic [CntW-1:0] depth_reg;
    mode_t           mode_reg;
    logic [63:0]     op1_reg, op2_reg;
    logic            empty_reg;
    logic [63:0]     res_reg;
    logic [1:0]      st_reg;
    logic            push_reg;
    logic [63:0]     out_val_reg;
    logic [1:0]      out_st_reg;
    logic            out_vld_reg;
    // op1 comes from memory only if the second pop found an entry
    logic            pop1_ok_reg;

    logic            ram_we;
    logic [PtrW-1:0] ram_waddr, ram_raddr;
    logic [63:0]     ram_rdata;
    div_req_t        dreq;
    div_rsp_t        drsp;

    // multiplier partial products, each stage registered
    logic [63:0] ua_reg, ub_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic        mneg_reg;

    logic        accept;
    logic        full;
    logic        zdiv;
    logic [63:0] sum, dif, mag1, mag2;
    logic [63:0] mid, hi, mmag;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !out_vld_reg;
    assign full     = depth_reg == CntW'(StackDepth);

    assign ram_raddr = PtrW'(depth_reg - CntW'(1));
    assign ram_we    = (state_reg == S_WB) && push_reg && !full;
    assign ram_waddr = depth_reg[PtrW-1:0];

    rpn_stack_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (res_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign sum  = op1_reg + op2_reg;
    assign dif  = op1_reg - op2_reg;
    assign mag1 = op1_reg[63] ? (64'd0 - op1_reg) : op1_reg;
    assign mag2 = op2_reg[63] ? (64'd0 - op2_reg) : op2_reg;

    // div by zero, or mod by a divisor whose integer part is zero
    assign zdiv = (mode_reg == MODE_DIV && op2_reg == '0)
                  || (mode_reg == MODE_MOD && mag2[63:32] == '0);

    assign mid  = {32'd0, p00_reg[63:32]} + {32'd0, p01_reg[31:0]} + {32'd0, p10_reg[31:0]};
    assign hi   = p11_reg + {32'd0, p01_reg[63:32]} + {32'd0, p10_reg[63:32]}
                  + {32'd0, mid[63:32]};
    assign mmag = {hi[31:0], mid[31:0]};

    function automatic logic [63:0] sat(input logic neg, input logic [63:0] m,
                                        input logic ovf);
        logic [63:0] r;
        if (neg)
        begin
            r = (ovf || m > QMin) ? QMin : (64'd0 - m);
        end
        else
        begin
            r = (ovf || m > QMax) ? QMax : m;
        end
        return r;
    endfunction

    always_comb
    begin
        dreq.start    = (state_reg == S_GOT1) && !zdiv
                        && (mode_reg == MODE_DIV || mode_reg == MODE_MOD);
        dreq.is_mod   = mode_reg == MODE_MOD;
        // mod feeds the integer part through the top 64 dividend bits
        dreq.dividend = (mode_reg == MODE_MOD) ? {32'd0, mag1[63:32], 32'd0}
                                               : {mag1, 32'd0};
        dreq.divisor  = (mode_reg == MODE_MOD) ? {32'd0, mag2[63:32]} : mag2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode_t'(s_tdata[2:0]))
                            MODE_PUSH: state_reg <= S_WB;
                            MODE_NONE: state_reg <= S_OUT;
                            default:   state_reg <= S_RD2;
                        endcase
                    end
                end
                S_RD2:
                begin
                    if (depth_reg != '0)
                    begin
                        depth_reg <= depth_reg - CntW'(1);
                    end
                    state_reg <= S_GOT2;
                end
                S_GOT2:
                begin
                    // pop op1 for binary ops; print is done
                    if (mode_reg == MODE_PRINT)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (depth_reg != '0)
                        begin
                            depth_reg <= depth_reg - CntW'(1);
                        end
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:   state_reg <= S_GOT1;
                S_GOT1:
                begin
                    case (mode_reg)
                        MODE_MUL: state_reg <= S_MUL1;
                        MODE_DIV:
                        begin
                            state_reg <= (op2_reg == '0) ? S_OUT : S_DIVW;
                        end
                        MODE_MOD:
                        begin
                            state_reg <= (mag2[63:32] == '0) ? S_OUT : S_DIVW;
                        end
                        default: state_reg <= S_WB;
                    endcase
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_MUL3;
                S_MUL3:  state_reg <= S_WB;
                S_DIVW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (ram_we)
                    begin
                        depth_reg <= depth_reg + CntW'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_vld_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg  <= mode_t'(s_tdata[2:0]);
                res_reg   <= (s_tdata[2:0] == MODE_NONE) ? 64'd0 : s_tdata[66:3];
                empty_reg <= 1'b0;
                st_reg    <= ST_OK;
                push_reg  <= s_tdata[2:0] == MODE_PUSH;
                op1_reg   <= '0;
                op2_reg   <= '0;
            end
            S_RD2:
            begin
                if (depth_reg == '0)
                begin
                    empty_reg <= 1'b1;
                end
            end
            S_GOT2:
            begin
                op2_reg <= empty_reg ? 64'd0 : ram_rdata;
                res_reg <= empty_reg ? 64'd0 : ram_rdata;
                if (mode_reg == MODE_PRINT && empty_reg)
                begin
                    st_reg <= ST_EMPTY;
                end
                if (depth_reg == '0)
                begin
                    empty_reg <= 1'b1;
                end
            end
            S_RD1:
            begin
                // op1 read was issued at S_GOT2 edge; data valid now
                op1_reg <= pop1_ok_reg ? ram_rdata : 64'd0;
            end
            S_GOT1:
            begin
                push_reg <= 1'b1;
                // a zero divisor outranks an empty pop
                if (zdiv)
                begin
                    st_reg <= ST_ZDIV;
                end
                else if (empty_reg)
                begin
                    st_reg <= ST_EMPTY;
                end
                ua_reg   <= mag1;
                ub_reg   <= mag2;
                mneg_reg <= op1_reg[63] ^ op2_reg[63];
                if (zdiv)
                begin
                    res_reg <= '0;
                end
                else
                begin
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            res_reg <= (op1_reg[63] == op2_reg[63] && sum[63] != op1_reg[63])
                                       ? (op1_reg[63] ? QMin : QMax) : sum;
                        end
                        MODE_SUB:
                        begin
                            res_reg <= (op1_reg[63] != op2_reg[63] && dif[63] != op1_reg[63])
                                       ? (op1_reg[63] ? QMin : QMax) : dif;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL1:
            begin
                p00_reg <= {32'd0, ua_reg[31:0]} * {32'd0, ub_reg[31:0]};
                p01_reg <= {32'd0, ua_reg[31:0]} * {32'd0, ub_reg[63:32]};
                p10_reg <= {32'd0, ua_reg[63:32]} * {32'd0, ub_reg[31:0]};
                p11_reg <= {32'd0, ua_reg[63:32]} * {32'd0, ub_reg[63:32]};
            end
            S_MUL3:
            begin
                res_reg <= sat(mneg_reg, mmag, hi[63:32] != '0);
            end
            S_MUL2: ;
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    if (mode_reg == MODE_MOD)
                    begin
                        res_reg <= op1_reg[63] ? (64'd0 - {drsp.rem[31:0], 32'd0})
                                               : {drsp.rem[31:0], 32'd0};
                    end
                    else
                    begin
                        res_reg <= sat(mneg_reg, drsp.quot, drsp.ovf);
                    end
                end
            end
            S_WB:
            begin
                if (push_reg && full && st_reg == ST_OK)
                begin
                    st_reg <= ST_FULL;
                end
            end
            S_OUT:
            begin
                out_val_reg <= res_reg;
                out_st_reg  <= st_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_GOT2)
        begin
            pop1_ok_reg <= depth_reg != '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_st_reg, out_val_reg};

    // the stack never grows past its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CntW'(StackDepth))
        else $error("stack depth overflow");
    // no new word while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !s_tready)
        else $error("accept while result pending");
    // memory writes only with room on the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !full)
        else $error("write to full stack");
    // a write bumps the depth by one
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> depth_reg == $past(depth_reg) + CntW'(1))
        else $error("depth not advanced after push");
endmodule

FILE: rtl/core/rpn_stack_ram.sv
// Operand stack memory: one write port, one registered read port.
module rpn_stack_ram
    import rpn_pkg::*;
(
    input  logic            clk,
    input  logic            we,
    input  logic [PtrW-1:0] waddr,
    input  logic [63:0]     wdata,
    input  logic [PtrW-1:0] raddr,
    output logic [63:0]     rdata
);
    logic [63:0] mem [StackDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/rpn_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module rpn_divider
    import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [95:0] dvd_reg;
    logic [63:0] dvs_reg;
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic        ovf_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic        ge;

    assign shifted = {rem_reg[63:0], dvd_reg[95]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                // mod divides the 32-bit integer parts only
                cnt_reg  <= req.is_mod ? 7'd64 : 7'd96;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[94:0], 1'b0};
            rem_reg <= ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg <= {quo_reg[62:0], ge};
            if (quo_reg[63])
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg[63:0];
endmodule

FILE: verif/tb_rpn_stack_calculator.sv
// Testbench for the RPN stack calculator: predicted results checked word by word.
module tb_rpn_stack_calculator
    import rpn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ONE = 64'h0000_0001_0000_0000;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] number;
    } op_word_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } res_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    rpn_stack_calculator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state: a mirror of the operand stack.
    logic [63:0] calc_stack [StackDepth];
    int          calc_depth;

    op_word_t    pending_ops [$];
    res_word_t   expected_results [$];
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic logic [63:0] saturate(input bit neg, input logic [63:0] mag,
                                             input bit ovf);
        if (neg)
            return (ovf || mag > QMin) ? QMin : (64'd0 - mag);
        return (ovf || mag > QMax) ? QMax : mag;
    endfunction

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] fx_add(input logic [63:0] a, input logic [63:0] b,
                                          input bit subtract);
        logic [63:0] s;
        s = subtract ? a - b : a + b;
        // overflow when operands as used agree in sign and the sum flips
        if (subtract ? (a[63] != b[63] && s[63] != a[63])
                     : (a[63] == b[63] && s[63] != a[63]))
            return a[63] ? QMin : QMax;
        return s;
    endfunction

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        return saturate(a[63] != b[63], p[95:32], p[127:96] != 0);
    endfunction

    function automatic logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] q;
        q = {32'd0, magnitude(a), 32'd0} / {64'd0, magnitude(b)};
        return saturate(a[63] != b[63], q[63:0], q[127:64] != 0);
    endfunction

    function automatic logic [63:0] pop_operand(inout bit empty);
        if (calc_depth > 0)
        begin
            calc_depth--;
            return calc_stack[calc_depth];
        end
        empty = 1'b1;
        return 64'd0;
    endfunction

    function automatic bit push_operand(input logic [63:0] v);
        if (calc_depth < StackDepth)
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic res_word_t evaluate(input op_word_t op);
        res_word_t r;
        bit empty;
        bit zdiv;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [31:0] ia;
        logic [31:0] ib;
        r = '0;
        empty = 1'b0;
        zdiv = 1'b0;
        case (mode_t'(op.mode))
            MODE_PUSH:
            begin
                r.value = op.number;
                if (!push_operand(op.number))
                    r.status = ST_FULL;
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD:
            begin
                b = pop_operand(empty);
                a = pop_operand(empty);
                case (mode_t'(op.mode))
                    MODE_ADD: r.value = fx_add(a, b, 1'b0);
                    MODE_SUB: r.value = fx_add(a, b, 1'b1);
                    MODE_MUL: r.value = fx_mul(a, b);
                    MODE_DIV:
                        if (b == 0)
                            zdiv = 1'b1;
                        else
                            r.value = fx_div(a, b);
                    default:
                    begin
                        ma = magnitude(a);
                        mb = magnitude(b);
                        ia = ma[63:32];
                        ib = mb[63:32];
                        if (ib == 0)
                            zdiv = 1'b1;
                        else
                        begin
                            r.value = {ia % ib, 32'd0};
                            if (a[63])
                                r.value = 64'd0 - r.value;
                        end
                    end
                endcase
                if (zdiv)
                begin
                    r.value = '0;
                    r.status = ST_ZDIV;
                end
                else
                begin
                    if (empty)
                        r.status = ST_EMPTY;
                    if (!push_operand(r.value) && r.status == ST_OK)
                        r.status = ST_FULL;
                end
            end
            MODE_PRINT:
            begin
                r.value = pop_operand(empty);
                if (empty)
                    r.status = ST_EMPTY;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: advance to the next pending word once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                op_word_t op;
                op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, op.number, op.mode};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Predict on accept, using the word currently on the bus.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(evaluate('{mode: s_tdata[2:0],
                                                  number: s_tdata[66:3]}));
    end

    // Receiver backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
            else
            begin
                res_word_t want;
                want = expected_results.pop_front();
                if (m_tdata[63:0] !== want.value)
                    report_mismatch("value", m_tdata[63:0], want.value);
                if (m_tdata[65:64] !== want.status)
                    report_mismatch("status", {62'd0, m_tdata[65:64]}, {62'd0, want.status});
                if (m_tdata[71:66] !== 6'd0)
                    report_mismatch("pad", {58'd0, m_tdata[71:66]}, 64'd0);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand_q();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = {{33{v[63]}}, v[30:0]};                 // small values, either sign
            1: v = {{20{v[63]}}, v[43:0]};
            2: v = (v[0] ? QMax : QMin) ^ {63'd0, v[1]};
            3: v = {{29{v[63]}}, v[34:32], 32'd0};          // whole small numbers
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_op(input mode_t m, input logic [63:0] n);
        pending_ops.push_back('{mode: m, number: n});
    endtask

    // Well-formed: push a few, then reduce with operators, then print.
    task automatic queue_expression();
        int n;
        n = $urandom_range(2, 5);
        for (int i = 0; i < n; i++)
            queue_op(MODE_PUSH, rand_q());
        for (int i = 1; i < n; i++)
            queue_op(mode_t'($urandom_range(MODE_ADD, MODE_MOD)), 64'd0);
        queue_op(MODE_PRINT, 64'd0);
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        int count;
        rst_n = 1'b0;
        cycles = 0;
        mismatches = 0;
        calc_depth = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pops, every operation, zero divisors, saturation.
        queue_op(MODE_PRINT, 64'd0);
        queue_op(MODE_ADD, 64'd0);
        queue_op(MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_op(MODE_PUSH, QMax);
        queue_op(MODE_PUSH, QMax);
        queue_op(MODE_ADD, 64'd0);
        queue_op(MODE_PUSH, QMin);
        queue_op(MODE_SUB, 64'd0);
        queue_op(MODE_PUSH, QMin);
        queue_op(MODE_MUL, 64'd0);
        queue_op(MODE_PUSH, 64'd0);
        queue_op(MODE_DIV, 64'd0);
        queue_op(MODE_PUSH, -64'sd7 * ONE);
        queue_op(MODE_PUSH, 64'h0000_0000_8000_0000);
        queue_op(MODE_MOD, 64'd0);
        queue_op(MODE_PUSH, -64'sd7 * ONE - 64'd5);
        queue_op(MODE_PUSH, 64'd3 * ONE + 64'd9);
        queue_op(MODE_MOD, 64'd0);
        queue_op(MODE_PUSH, 64'd1);
        queue_op(MODE_DIV, 64'd0);
        queue_op(MODE_PUSH, QMin);
        queue_op(MODE_PUSH, -64'sd1 * ONE);
        queue_op(MODE_DIV, 64'd0);
        queue_op(MODE_PRINT, 64'd0);
        drain();

        // Fill the stack past full, then empty it again.
        for (int i = 0; i < StackDepth + 3; i++)
            queue_op(MODE_PUSH, rand_q());
        queue_op(MODE_ADD, 64'd0);
        for (int i = 0; i < StackDepth + 2; i++)
            queue_op(MODE_PRINT, 64'd0);
        drain();

        // Random phases with differing idle patterns.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 11 : 76) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 11 : 76) : 0;
            count = 0;
            while (count < 316)
            begin
                if ($urandom_range(9) < 8)
                begin
                    queue_expression();
                    count += 7;
                end
                else
                begin
                    queue_op(mode_t'($urandom_range(MODE_PUSH, MODE_NONE)), rand_q());
                    count++;
                end
            end
            if (phase == 0)
            begin
                // long receiver hold-off while the sender keeps offering words
                hold_off = 1'b1;
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
